/* rtl/lprl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Longest prefix route lookup package
// Operation codes and the item carried from cell to cell along the chain.
// ----------------------------------------------------------------------------

package lprl_pkg;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_WRITE  = 1'b1;

	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned PORT_W  = 8;
	localparam int unsigned INDEX_W = 6;

	typedef struct packed {
		logic               opcode;
		logic [INDEX_W-1:0] index;
		logic [ADDR_W-1:0]  prefix;
		logic [ADDR_W-1:0]  mask;
		logic [ADDR_W-1:0]  gw_addr;
		logic [PORT_W-1:0]  port;
		logic               enable;
		logic [ADDR_W-1:0]  dest;
		logic               hit;
		logic [ADDR_W-1:0]  best_mask;
		logic [ADDR_W-1:0]  best_hop;
		logic [PORT_W-1:0]  best_port;
	} lprl_token_t;

endpackage

`default_nettype wire

/* rtl/lprl_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Route cell
// Holds one table entry. A write item addressed to this cell loads the
// entry; a lookup item is compared against it and takes over the entry when
// it is a better match. Every item moves on to the next cell.
// ----------------------------------------------------------------------------

module lprl_cell
	import lprl_pkg::*;
#(
	parameter int unsigned CELL_INDEX = 0
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire logic        tok_valid_in,
	input  wire lprl_token_t tok_in,
	output logic             tok_valid_out,
	output lprl_token_t      tok_out
);

	logic              ent_valid_q;
	logic [ADDR_W-1:0] ent_prefix_q;
	logic [ADDR_W-1:0] ent_mask_q;
	logic [ADDR_W-1:0] ent_hop_q;
	logic [PORT_W-1:0] ent_port_q;
	logic              tok_valid_q;
	lprl_token_t       tok_q;
	lprl_token_t       tok_d;
	logic              wr_sel;
	logic              match;
	logic              better;

	assign wr_sel = advance && tok_valid_in && (tok_in.opcode == OP_WRITE)
		&& (32'(tok_in.index) == CELL_INDEX);
	assign match  = ent_valid_q && ((tok_in.dest & ent_mask_q) == ent_prefix_q);
	assign better = match && (!tok_in.hit || (ent_mask_q > tok_in.best_mask));

	always_comb begin
		tok_d = tok_in;
		if ((tok_in.opcode == OP_LOOKUP) && better) begin
			tok_d.hit       = 1'b1;
			tok_d.best_mask = ent_mask_q;
			tok_d.best_hop  = ent_hop_q;
			tok_d.best_port = ent_port_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
			tok_valid_q <= 1'b0;
		end else if (advance) begin
			tok_valid_q <= tok_valid_in;
			if (wr_sel) begin
				ent_valid_q <= tok_in.enable;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_sel) begin
			ent_prefix_q <= tok_in.prefix;
			ent_mask_q   <= tok_in.mask;
			ent_hop_q    <= tok_in.gw_addr;
			ent_port_q   <= tok_in.port;
		end
		if (advance) begin
			tok_q <= tok_d;
		end
	end

	assign tok_valid_out = tok_valid_q;
	assign tok_out       = tok_q;

endmodule

`default_nettype wire

/* rtl/longest_prefix_route_lookup_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Longest prefix route lookup unit
// IPv4 route table with longest prefix match, built as a chain of cells.
// ----------------------------------------------------------------------------
// The table is a chain of TABLE_DEPTH cells, one route entry per cell. Every
// item, write or lookup, walks the chain one cell per cycle, so the unit takes
// one transfer per cycle while no result waits at the output. A lookup item
// passes through the register of each cell in turn and then through the
// output register before its result appears. Items keep their order through
// the chain, so a lookup always sees exactly the writes taken before it. A
// write produces no result. While a result waits at the output, the whole
// chain holds. No clearing pass follows reset.

module longest_prefix_route_lookup_unit
	import lprl_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               opcode,
	input  wire logic [INDEX_W-1:0] entry_index,
	input  wire logic [ADDR_W-1:0]  entry_prefix,
	input  wire logic [ADDR_W-1:0]  entry_mask,
	input  wire logic [ADDR_W-1:0]  entry_next_hop,
	input  wire logic [PORT_W-1:0]  entry_port,
	input  wire logic               entry_enable,
	input  wire logic [ADDR_W-1:0]  dest_addr,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    found,
	output logic [ADDR_W-1:0]       next_hop_addr,
	output logic [PORT_W-1:0]       out_port
);

	logic              advance;
	logic              chain_valid [TABLE_DEPTH+1];
	lprl_token_t       chain_tok   [TABLE_DEPTH+1];
	logic              out_valid_q;
	logic              found_q;
	logic [ADDR_W-1:0] hop_q;
	logic [PORT_W-1:0] port_q;
	logic              last_is_lookup;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;

	always_comb begin
		chain_valid[0]        = in_valid;
		chain_tok[0].opcode    = opcode;
		chain_tok[0].index     = entry_index;
		chain_tok[0].prefix    = entry_prefix;
		chain_tok[0].mask      = entry_mask;
		chain_tok[0].gw_addr   = entry_next_hop;
		chain_tok[0].port      = entry_port;
		chain_tok[0].enable    = entry_enable;
		chain_tok[0].dest      = dest_addr;
		chain_tok[0].hit       = 1'b0;
		chain_tok[0].best_mask = '0;
		chain_tok[0].best_hop  = '0;
		chain_tok[0].best_port = '0;
	end

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		lprl_cell #(
			.CELL_INDEX(k)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.advance      (advance),
			.tok_valid_in (chain_valid[k]),
			.tok_in       (chain_tok[k]),
			.tok_valid_out(chain_valid[k+1]),
			.tok_out      (chain_tok[k+1])
		);
	end

	assign last_is_lookup = chain_valid[TABLE_DEPTH]
		&& (chain_tok[TABLE_DEPTH].opcode == OP_LOOKUP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= last_is_lookup;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			found_q <= chain_tok[TABLE_DEPTH].hit;
			hop_q   <= chain_tok[TABLE_DEPTH].best_hop;
			port_q  <= chain_tok[TABLE_DEPTH].best_port;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign next_hop_addr = hop_q;
	assign out_port      = port_q;

`ifndef ASSERT_OFF
	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> ((next_hop_addr == '0) && (out_port == '0)))
		else $error("A missed lookup carries a nonzero next hop or port.");

	a_chain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && chain_valid[TABLE_DEPTH]) |=>
		(out_valid == ($past(chain_tok[TABLE_DEPTH].opcode) == OP_LOOKUP)))
		else $error("Chain end item did not map to exactly its own result.");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!advance && chain_valid[TABLE_DEPTH]) |=> chain_valid[TABLE_DEPTH])
		else $error("An item left the chain end while the output was stalled.");
`endif

endmodule

`default_nettype wire
